// ===== design/cic_pkg.sv =====
// shared types, constants and helpers for the two-level cache controller
package cic_pkg;

   // address split: 64-byte lines
   localparam int OFF_W   = 6;
   localparam int LINE_W  = 32 - OFF_W;
   localparam int IS_W    = 9;
   localparam int IT_W    = LINE_W - IS_W;
   localparam int DS_W    = 8;
   localparam int DT_W    = LINE_W - DS_W;
   localparam int DWAYS   = 2;
   localparam int L2S_W   = 13;
   localparam int L2T_W   = LINE_W - L2S_W;
   localparam int L2WAYS  = 4;
   localparam int ISETS   = 1 << IS_W;
   localparam int DSETS   = 1 << DS_W;
   localparam int L2SETS  = 1 << L2S_W;
   localparam int CNT_N   = 6;

   // counter slots
   localparam int CNT_IACC  = 0;
   localparam int CNT_IMISS = 1;
   localparam int CNT_DACC  = 2;
   localparam int CNT_DMISS = 3;
   localparam int CNT_L2ACC = 4;
   localparam int CNT_L2MISS = 5;

   // access codes
   localparam logic [1:0] FUNC_IFETCH = 2'd0;
   localparam logic [1:0] FUNC_DREAD  = 2'd1;
   localparam logic [1:0] FUNC_DWRITE = 2'd2;

   // memory operation codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // register map
   localparam logic [2:0] CSR_MODE_ADDR = 3'd0;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
   } req_item_type;

   typedef struct packed {
      logic        last;
      logic [1:0]  mem_op;
      logic [31:0] line_address;
      logic        l1_hit;
      logic        l2_hit;
      logic [31:0] l1i_accesses;
      logic [31:0] l1i_misses;
      logic [31:0] l1d_accesses;
      logic [31:0] l1d_misses;
      logic [31:0] l2_accesses;
      logic [31:0] l2_misses;
   } rsp_item_type;

   typedef struct packed {
      logic            valid;
      logic [IT_W-1:0] tag;
   } i_entry_type;

   typedef struct packed {
      logic            valid;
      logic            dirty;
      logic [DT_W-1:0] tag;
      logic [31:0]     stamp;
   } d_entry_type;

   typedef d_entry_type [DWAYS-1:0] d_row_type;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [L2T_W-1:0] tag;
      logic [31:0]      stamp;
   } l2_entry_type;

   typedef l2_entry_type [L2WAYS-1:0] l2_row_type;

   // one-hot sequencer states
   typedef enum logic [20:0] {
      S_CLR     = 21'h000001,
      S_IDLE    = 21'h000002,
      S_START   = 21'h000004,
      S_I_CHK   = 21'h000008,
      S_F_CHK   = 21'h000010,
      S_F_L2    = 21'h000020,
      S_L2_RD   = 21'h000040,
      S_L2_CHK  = 21'h000080,
      S_EV_IRD  = 21'h000100,
      S_EV_ICHK = 21'h000200,
      S_EV_DCHK = 21'h000400,
      S_L2_WR   = 21'h000800,
      S_I_FIN   = 21'h001000,
      S_W_INV   = 21'h002000,
      S_D_CHK   = 21'h004000,
      S_D_RD2   = 21'h008000,
      S_D_VIC   = 21'h010000,
      S_D_RD3   = 21'h020000,
      S_D_LAT   = 21'h040000,
      S_D_WR    = 21'h080000,
      S_SUM     = 21'h100000
   } state_type;

   // galois lfsr step, shift right
   function automatic logic [15:0] lfsr_step(input logic [15:0] v);
      lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
   endfunction

endpackage

// ===== design/cic_ram.sv =====
// simple dual-port ram, registered read
module cic_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== design/two_level_inclusive_cache_controller.sv =====
// top level: tag and status controller for an instruction l1, data l1 and inclusive l2
//
// Usage:
//   Input channel: drive req_item and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy stays high until the whole
//   item is done, so one item is in flight at a time.
//   Result channel: each memory line read or write the access causes appears on
//   rsp_item for one cycle with rsp_strobe high, in order, then one summary with
//   last set carrying hit flags and the six counters. The receiver cannot stall.
//   Timing: a first-level hit goes from the l1 check straight to its summary; a
//   store first checks the instruction copy; a miss walks the tag memories one
//   read-modify-write at a time, paced by the single read port of each tag memory
//   and the eviction walk. The next item can be taken once busy is low, in the
//   cycle the summary appears on rsp_item.
//   Configuration: csr_ APB port, register 0 bit 0 selects random replacement.
//   Reset: synchronous; afterwards a clearing pass sweeps the tag memories, all
//   8192 l2 rows at one l2 row per cycle, with busy high. Config writes are taken
//   during the pass.
module two_level_inclusive_cache_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cic_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output cic_pkg::rsp_item_type rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import cic_pkg::*;

   state_type          state_ff, state_in;
   logic [L2S_W-1:0]   clr_ff, clr_in;
   logic               mode_ff, mode_in;
   logic [1:0]         func_ff, func_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [LINE_W-1:0]  acc_ff, acc_in;
   logic               kind_ff, kind_in;
   logic [LINE_W-1:0]  vic_ff, vic_in;
   l2_row_type         l2row_ff, l2row_in;
   logic [1:0]         l2way_ff, l2way_in;
   d_row_type          drow_ff, drow_in;
   logic               dway_ff, dway_in;
   logic               l1hit_ff, l1hit_in;
   logic               l2hit_ff, l2hit_in;
   logic [31:0]        cnt_ff [CNT_N];
   logic [31:0]        cnt_in [CNT_N];
   logic [31:0]        stamp_ff, stamp_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type       rsp_ff, rsp_in;

   // memory ports
   logic               i_we, i_re, d_we, d_re, l2_we, l2_re;
   logic [IS_W-1:0]    i_waddr, i_raddr;
   logic [DS_W-1:0]    d_waddr, d_raddr;
   logic [L2S_W-1:0]   l2_waddr, l2_raddr;
   i_entry_type        i_wdata, i_q;
   d_row_type          d_wdata, d_q;
   l2_row_type         l2_wdata, l2_q;

   // lookup results
   logic               l2_hit_any;
   logic [1:0]         l2_hit_way;
   logic [1:0]         l2_vic_way;
   logic               l2_all_valid;
   logic [DT_W-1:0]    d_cmp_tag;
   logic               d_match_any;
   logic               d_match_way;
   logic               d_dirty_any;
   logic               d_dirty_way;
   logic               d_vic_way;
   logic               d_all_valid;
   logic [31:0]        stamp_next;
   logic               csr_wr;
   state_type          ret_state;

   cic_ram #(.DEPTH(ISETS), .WIDTH($bits(i_entry_type))) u_iram (
      .clock(clock), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
      .re(i_re), .raddr(i_raddr), .rdata(i_q)
   );

   cic_ram #(.DEPTH(DSETS), .WIDTH($bits(d_row_type))) u_dram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .re(d_re), .raddr(d_raddr), .rdata(d_q)
   );

   cic_ram #(.DEPTH(L2SETS), .WIDTH($bits(l2_row_type))) u_l2ram (
      .clock(clock), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
      .re(l2_re), .raddr(l2_raddr), .rdata(l2_q)
   );

   assign stamp_next = stamp_ff + 32'd1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, mode_ff};
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // l2 row lookup against the line being accessed
   always_comb begin
      logic [1:0] lru;
      l2_hit_any   = 1'b0;
      l2_hit_way   = 2'd0;
      l2_all_valid = 1'b1;
      l2_vic_way   = 2'd0;
      lru          = 2'd0;
      for (int w = L2WAYS - 1; w >= 0; w--) begin
         if (l2_q[w].valid && (l2_q[w].tag == acc_ff[LINE_W-1:L2S_W])) begin
            l2_hit_any = 1'b1;
            l2_hit_way = w[1:0];
         end
      end
      for (int w = 1; w < L2WAYS; w++) begin
         if (l2_q[w].stamp < l2_q[lru].stamp) begin
            lru = w[1:0];
         end
      end
      if (mode_ff) begin
         l2_vic_way = lfsr_ff[1:0];
      end else begin
         l2_vic_way = lru;
      end
      for (int w = L2WAYS - 1; w >= 0; w--) begin
         if (!l2_q[w].valid) begin
            l2_all_valid = 1'b0;
            l2_vic_way   = w[1:0];
         end
      end
   end

   // data l1 row lookup
   always_comb begin
      d_cmp_tag   = (state_ff == S_EV_DCHK) ? vic_ff[LINE_W-1:DS_W] : line_ff[LINE_W-1:DS_W];
      d_match_any = 1'b0;
      d_match_way = 1'b0;
      d_dirty_any = 1'b0;
      d_dirty_way = 1'b0;
      for (int w = DWAYS - 1; w >= 0; w--) begin
         if (d_q[w].valid && (d_q[w].tag == d_cmp_tag)) begin
            d_match_any = 1'b1;
            d_match_way = w[0];
         end
         if (d_q[w].valid && d_q[w].dirty && (d_q[w].tag == d_cmp_tag)) begin
            d_dirty_any = 1'b1;
            d_dirty_way = w[0];
         end
      end
      d_all_valid = d_q[0].valid && d_q[1].valid;
      if (!d_q[0].valid) begin
         d_vic_way = 1'b0;
      end else if (!d_q[1].valid) begin
         d_vic_way = 1'b1;
      end else if (mode_ff) begin
         d_vic_way = lfsr_ff[0];
      end else begin
         d_vic_way = (d_q[1].stamp < d_q[0].stamp);
      end
   end

   // where an l2 access returns to
   always_comb begin
      if (func_ff == FUNC_IFETCH) begin
         ret_state = S_I_FIN;
      end else if (kind_ff) begin
         ret_state = S_D_RD3;
      end else begin
         ret_state = S_D_RD2;
      end
   end

   // sequencer
   always_comb begin
      i_entry_type  ie;
      d_row_type    dr;
      l2_row_type   lr;
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      func_in       = func_ff;
      line_in       = line_ff;
      acc_in        = acc_ff;
      kind_in       = kind_ff;
      vic_in        = vic_ff;
      l2row_in      = l2row_ff;
      l2way_in      = l2way_ff;
      drow_in       = drow_ff;
      dway_in       = dway_ff;
      l1hit_in      = l1hit_ff;
      l2hit_in      = l2hit_ff;
      cnt_in        = cnt_ff;
      stamp_in      = stamp_ff;
      lfsr_in       = lfsr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      i_we = 1'b0; i_re = 1'b0; d_we = 1'b0; d_re = 1'b0; l2_we = 1'b0; l2_re = 1'b0;
      i_waddr  = line_ff[IS_W-1:0];
      i_raddr  = line_ff[IS_W-1:0];
      d_waddr  = line_ff[DS_W-1:0];
      d_raddr  = line_ff[DS_W-1:0];
      l2_waddr = acc_ff[L2S_W-1:0];
      l2_raddr = acc_ff[L2S_W-1:0];
      i_wdata  = '0;
      d_wdata  = d_q;
      l2_wdata = l2_q;
      ie = '0;
      dr = d_q;
      lr = l2_q;

      // register write
      if (csr_wr && (csr_paddr == CSR_MODE_ADDR)) begin
         mode_in = csr_pwdata[0];
      end

      case (state_ff)
         S_CLR: begin
            i_we = 1'b1; d_we = 1'b1; l2_we = 1'b1;
            i_waddr  = clr_ff[IS_W-1:0];
            d_waddr  = clr_ff[DS_W-1:0];
            l2_waddr = clr_ff;
            d_wdata  = '0;
            l2_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in  = req_item.func;
               line_in  = req_item.address[31:OFF_W];
               state_in = S_START;
            end
         end
         S_START: begin
            l1hit_in = 1'b0;
            l2hit_in = 1'b0;
            case (func_ff)
               FUNC_IFETCH: begin
                  cnt_in[CNT_IACC] = cnt_ff[CNT_IACC] + 32'd1;
                  i_re = 1'b1;
                  state_in = S_I_CHK;
               end
               FUNC_DREAD: begin
                  cnt_in[CNT_DACC] = cnt_ff[CNT_DACC] + 32'd1;
                  d_re = 1'b1;
                  state_in = S_D_CHK;
               end
               FUNC_DWRITE: begin
                  cnt_in[CNT_DACC] = cnt_ff[CNT_DACC] + 32'd1;
                  i_re = 1'b1;
                  state_in = S_W_INV;
               end
               default: begin
                  state_in = S_SUM;
               end
            endcase
         end
         // instruction lookup
         S_I_CHK: begin
            if (i_q.valid && (i_q.tag == line_ff[LINE_W-1:IS_W])) begin
               l1hit_in = 1'b1;
               stamp_in = stamp_next;
               state_in = S_SUM;
            end else begin
               cnt_in[CNT_IMISS] = cnt_ff[CNT_IMISS] + 32'd1;
               d_re = 1'b1;
               state_in = S_F_CHK;
            end
         end
         // dirty data copy of a missing instruction line
         S_F_CHK: begin
            acc_in  = line_ff;
            kind_in = 1'b0;
            if (d_dirty_any) begin
               dr[d_dirty_way].dirty = 1'b0;
               d_wdata = dr;
               d_we    = 1'b1;
               l2_re   = 1'b1;
               l2_raddr = line_ff[L2S_W-1:0];
               state_in = S_F_L2;
            end else begin
               state_in = S_L2_RD;
            end
         end
         S_F_L2: begin
            if (l2_hit_any) begin
               lr[l2_hit_way].dirty = 1'b1;
               l2_wdata = lr;
               l2_we    = 1'b1;
            end else begin
               rsp_strobe_in       = 1'b1;
               rsp_in.mem_op       = MEM_WRITE;
               rsp_in.line_address = {line_ff, {OFF_W{1'b0}}};
            end
            state_in = S_L2_RD;
         end
         // l2 access: fill or writeback
         S_L2_RD: begin
            l2_re = 1'b1;
            state_in = S_L2_CHK;
         end
         S_L2_CHK: begin
            cnt_in[CNT_L2ACC] = cnt_ff[CNT_L2ACC] + 32'd1;
            if (l2_hit_any) begin
               lr[l2_hit_way].stamp = stamp_next;
               if (kind_ff) begin
                  lr[l2_hit_way].dirty = 1'b1;
               end else begin
                  l2hit_in = 1'b1;
               end
               stamp_in = stamp_next;
               l2_wdata = lr;
               l2_we    = 1'b1;
               state_in = ret_state;
            end else begin
               cnt_in[CNT_L2MISS] = cnt_ff[CNT_L2MISS] + 32'd1;
               l2row_in = l2_q;
               l2way_in = l2_vic_way;
               vic_in   = {l2_q[l2_vic_way].tag, acc_ff[L2S_W-1:0]};
               if (l2_all_valid && mode_ff) begin
                  lfsr_in = lfsr_step(lfsr_ff);
               end
               if (l2_q[l2_vic_way].valid) begin
                  if (l2_q[l2_vic_way].dirty) begin
                     rsp_strobe_in       = 1'b1;
                     rsp_in.mem_op       = MEM_WRITE;
                     rsp_in.line_address = {l2_q[l2_vic_way].tag, acc_ff[L2S_W-1:0],
                                            {OFF_W{1'b0}}};
                  end
                  state_in = S_EV_IRD;
               end else begin
                  state_in = S_L2_WR;
               end
            end
         end
         // back-invalidate the l1 copies of the l2 victim
         S_EV_IRD: begin
            i_re = 1'b1;
            i_raddr = vic_ff[IS_W-1:0];
            state_in = S_EV_ICHK;
         end
         S_EV_ICHK: begin
            if (i_q.valid && (i_q.tag == vic_ff[LINE_W-1:IS_W])) begin
               i_we    = 1'b1;
               i_waddr = vic_ff[IS_W-1:0];
            end
            d_re = 1'b1;
            d_raddr = vic_ff[DS_W-1:0];
            state_in = S_EV_DCHK;
         end
         S_EV_DCHK: begin
            if (d_match_any) begin
               if (d_q[d_match_way].dirty) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.mem_op       = MEM_WRITE;
                  rsp_in.line_address = {vic_ff, {OFF_W{1'b0}}};
               end
               dr[d_match_way].valid = 1'b0;
               dr[d_match_way].dirty = 1'b0;
               d_wdata = dr;
               d_we    = 1'b1;
               d_waddr = vic_ff[DS_W-1:0];
            end
            state_in = S_L2_WR;
         end
         // install the new l2 line
         S_L2_WR: begin
            lr = l2row_ff;
            lr[l2way_ff].valid = 1'b1;
            lr[l2way_ff].dirty = kind_ff;
            lr[l2way_ff].tag   = acc_ff[LINE_W-1:L2S_W];
            lr[l2way_ff].stamp = stamp_next;
            stamp_in = stamp_next;
            l2_wdata = lr;
            l2_we    = 1'b1;
            if (!kind_ff) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.mem_op       = MEM_READ;
               rsp_in.line_address = {acc_ff, {OFF_W{1'b0}}};
            end
            state_in = ret_state;
         end
         S_I_FIN: begin
            ie.valid = 1'b1;
            ie.tag   = line_ff[LINE_W-1:IS_W];
            i_wdata  = ie;
            i_we     = 1'b1;
            stamp_in = stamp_next;
            state_in = S_SUM;
         end
         // store drops the instruction copy
         S_W_INV: begin
            if (i_q.valid && (i_q.tag == line_ff[LINE_W-1:IS_W])) begin
               i_we = 1'b1;
            end
            d_re = 1'b1;
            state_in = S_D_CHK;
         end
         S_D_CHK: begin
            if (d_match_any) begin
               l1hit_in = 1'b1;
               if (func_ff == FUNC_DWRITE) begin
                  dr[d_match_way].dirty = 1'b1;
               end
               dr[d_match_way].stamp = stamp_next;
               stamp_in = stamp_next;
               d_wdata  = dr;
               d_we     = 1'b1;
               state_in = S_SUM;
            end else begin
               cnt_in[CNT_DMISS] = cnt_ff[CNT_DMISS] + 32'd1;
               acc_in   = line_ff;
               kind_in  = 1'b0;
               state_in = S_L2_RD;
            end
         end
         // pick the data l1 victim after the fill
         S_D_RD2: begin
            d_re = 1'b1;
            state_in = S_D_VIC;
         end
         S_D_VIC: begin
            dway_in = d_vic_way;
            drow_in = d_q;
            if (d_all_valid && mode_ff) begin
               lfsr_in = lfsr_step(lfsr_ff);
            end
            if (d_q[d_vic_way].valid && d_q[d_vic_way].dirty) begin
               acc_in   = {d_q[d_vic_way].tag, line_ff[DS_W-1:0]};
               kind_in  = 1'b1;
               state_in = S_L2_RD;
            end else begin
               state_in = S_D_WR;
            end
         end
         S_D_RD3: begin
            d_re = 1'b1;
            state_in = S_D_LAT;
         end
         S_D_LAT: begin
            drow_in  = d_q;
            state_in = S_D_WR;
         end
         S_D_WR: begin
            dr = drow_ff;
            dr[dway_ff].valid = 1'b1;
            dr[dway_ff].dirty = (func_ff == FUNC_DWRITE);
            dr[dway_ff].tag   = line_ff[LINE_W-1:DS_W];
            dr[dway_ff].stamp = stamp_next;
            stamp_in = stamp_next;
            d_wdata  = dr;
            d_we     = 1'b1;
            state_in = S_SUM;
         end
         // summary item
         S_SUM: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.last         = 1'b1;
            rsp_in.mem_op       = MEM_NONE;
            rsp_in.line_address = {line_ff, {OFF_W{1'b0}}};
            rsp_in.l1_hit       = l1hit_ff;
            rsp_in.l2_hit       = l2hit_ff;
            rsp_in.l1i_accesses = cnt_ff[CNT_IACC];
            rsp_in.l1i_misses   = cnt_ff[CNT_IMISS];
            rsp_in.l1d_accesses = cnt_ff[CNT_DACC];
            rsp_in.l1d_misses   = cnt_ff[CNT_DMISS];
            rsp_in.l2_accesses  = cnt_ff[CNT_L2ACC];
            rsp_in.l2_misses    = cnt_ff[CNT_L2MISS];
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         mode_ff       <= 1'b0;
         stamp_ff      <= '0;
         lfsr_ff       <= 16'd1;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < CNT_N; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         mode_ff       <= mode_in;
         stamp_ff      <= stamp_in;
         lfsr_ff       <= lfsr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      line_ff  <= line_in;
      acc_ff   <= acc_in;
      kind_ff  <= kind_in;
      vic_ff   <= vic_in;
      l2row_ff <= l2row_in;
      l2way_ff <= l2way_in;
      drow_ff  <= drow_in;
      dway_ff  <= dway_in;
      l1hit_ff <= l1hit_in;
      l2hit_ff <= l2hit_in;
      rsp_ff   <= rsp_in;
   end
endmodule
